>>> hdl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 border-aware box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int SAMPLE_W   = 16;     // sample field width on the ports
    localparam int OUT_POS_W  = 10;     // column and row field width
    localparam int SIDE_W     = 11;     // grid side register width
    localparam int SUM_W      = 20;     // nine samples plus rounding bias
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;     // 36 payload bits padded to bytes

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(257);

    typedef logic [SAMPLE_W-1:0] t_sample;

    // result kinds relative to the incoming pixel, in issue order
    typedef enum logic [1:0] {
        RES_UL   = 2'd0,    // pixel above-left
        RES_UP   = 2'd1,    // pixel above, end of row
        RES_LEFT = 2'd2,    // pixel to the left, last row
        RES_SELF = 2'd3     // the pixel itself, end of frame
    } t_res_kind;

    // one classified pixel handed from the front to the back
    typedef struct packed {
        t_sample [8:0]          win;    // index 3*j+i: column c-j, row r-2+i
        logic [OUT_POS_W-1:0]   row;
        logic [OUT_POS_W-1:0]   col;
        logic                   r_ge1;
        logic                   r_ge2;
        logic                   c_ge1;
        logic                   c_ge2;
        logic [3:0]             res;    // results to produce, by t_res_kind
    } t_job;

endpackage

>>> hdl/bb3_front.sv
// ----------------------------------------------------------------------------
// bb3_front
// Tracks grid position, keeps the two line buffers and the window columns,
// and turns each sample into a job that lists the results it releases.
// ----------------------------------------------------------------------------
module bb3_front #(
    parameter int MAX_SIDE    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [bb3_pkg::SIDE_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bb3_pkg::SAMPLE_W-1:0] i_height,
    input  logic                        i_frame_start,
    output logic                        o_job_valid,
    input  logic                        i_job_ready,
    output bb3_pkg::t_job               o_job
);
    import bb3_pkg::*;

    localparam int POS_W = $clog2(MAX_SIDE);
    localparam int CNT_W = POS_W + 1;
    localparam int SW    = (SIDE_W > CNT_W) ? SIDE_W : CNT_W;
    localparam int DW    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

    logic [SIDE_W-1:0]      r_side;
    logic [POS_W-1:0]       r_col;
    logic [POS_W-1:0]       r_row;

    logic                   r_f2_valid;
    logic [DW-1:0]          r_f2_x;
    logic [POS_W-1:0]       r_f2_col;
    logic [POS_W-1:0]       r_f2_row;
    logic [3:0]             r_f2_res;
    logic                   r_f2_r_ge1;
    logic                   r_f2_r_ge2;
    logic                   r_f2_c_ge1;
    logic                   r_f2_c_ge2;
    logic                   r_fwd;
    logic [DW-1:0]          r_fwd_prev;
    logic [DW-1:0]          r_fwd_prev2;
    logic [DW-1:0]          r_rd_prev;
    logic [DW-1:0]          r_rd_prev2;
    logic [5:0][DW-1:0]     r_win;

    logic [DW-1:0]          r_mem_prev  [MAX_SIDE];
    logic [DW-1:0]          r_mem_prev2 [MAX_SIDE];

    logic [SW-1:0]          side_ext;
    logic [CNT_W-1:0]       side;
    logic [CNT_W-1:0]       pos_col;
    logic [CNT_W-1:0]       pos_row;
    logic [CNT_W-1:0]       n_col;
    logic [CNT_W-1:0]       n_row;
    logic [POS_W-1:0]       cur_col;
    logic [POS_W-1:0]       cur_row;
    logic                   col_last;
    logic                   row_last;
    logic                   accept;
    logic                   f2_adv;
    logic [DW-1:0]          prev_eff;
    logic [DW-1:0]          prev2_eff;

    // side clamped to 1..MAX_SIDE
    always_comb begin
        side_ext = SW'(r_side);
        if (side_ext == '0) begin
            side = CNT_W'(1);
        end else if (side_ext > SW'(MAX_SIDE)) begin
            side = CNT_W'(MAX_SIDE);
        end else begin
            side = CNT_W'(side_ext);
        end
    end

    // position of the incoming sample and the one after it
    always_comb begin
        pos_col = i_frame_start ? '0 : CNT_W'(r_col);
        pos_row = i_frame_start ? '0 : CNT_W'(r_row);
        if (pos_col >= side) begin
            pos_col = '0;
            pos_row = pos_row + CNT_W'(1);
        end
        if (pos_row >= side) begin
            pos_row = '0;
        end
        cur_col  = POS_W'(pos_col);
        cur_row  = POS_W'(pos_row);
        col_last = (pos_col == side - CNT_W'(1));
        row_last = (pos_row == side - CNT_W'(1));
        n_col    = pos_col + CNT_W'(1);
        n_row    = pos_row;
        if (n_col >= side) begin
            n_col = '0;
            n_row = pos_row + CNT_W'(1);
            if (n_row >= side) begin
                n_row = '0;
            end
        end
    end

    assign prev_eff  = r_fwd ? r_fwd_prev  : r_rd_prev;
    assign prev2_eff = r_fwd ? r_fwd_prev2 : r_rd_prev2;

    assign o_job_valid = r_f2_valid && (r_f2_res != '0);
    assign f2_adv      = r_f2_valid && ((r_f2_res == '0) || i_job_ready);
    assign o_ready     = !r_f2_valid || f2_adv;
    assign accept      = i_valid && o_ready;

    always_comb begin
        o_job.win[0] = SAMPLE_W'(prev2_eff);
        o_job.win[1] = SAMPLE_W'(prev_eff);
        o_job.win[2] = SAMPLE_W'(r_f2_x);
        o_job.win[3] = SAMPLE_W'(r_win[0]);
        o_job.win[4] = SAMPLE_W'(r_win[1]);
        o_job.win[5] = SAMPLE_W'(r_win[2]);
        o_job.win[6] = SAMPLE_W'(r_win[3]);
        o_job.win[7] = SAMPLE_W'(r_win[4]);
        o_job.win[8] = SAMPLE_W'(r_win[5]);
        o_job.row    = OUT_POS_W'(r_f2_row);
        o_job.col    = OUT_POS_W'(r_f2_col);
        o_job.r_ge1  = r_f2_r_ge1;
        o_job.r_ge2  = r_f2_r_ge2;
        o_job.c_ge1  = r_f2_c_ge1;
        o_job.c_ge2  = r_f2_c_ge2;
        o_job.res    = r_f2_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side     <= SIDE_RESET;
            r_col      <= '0;
            r_row      <= '0;
            r_f2_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_side <= i_cfg_data;
            end
            if (accept) begin
                r_col <= POS_W'(n_col);
                r_row <= POS_W'(n_row);
            end
            if (accept) begin
                r_f2_valid <= 1'b1;
            end else if (f2_adv) begin
                r_f2_valid <= 1'b0;
            end
            if (f2_adv) begin
                r_win[3] <= r_win[0];
                r_win[4] <= r_win[1];
                r_win[5] <= r_win[2];
                r_win[0] <= prev2_eff;
                r_win[1] <= prev_eff;
                r_win[2] <= r_f2_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f2_x                <= DW'(i_height);
            r_f2_col              <= cur_col;
            r_f2_row              <= cur_row;
            r_f2_r_ge1            <= (cur_row != '0);
            r_f2_r_ge2            <= (cur_row > POS_W'(1));
            r_f2_c_ge1            <= (cur_col != '0);
            r_f2_c_ge2            <= (cur_col > POS_W'(1));
            r_f2_res[RES_UL]      <= (cur_row != '0) && (cur_col != '0);
            r_f2_res[RES_UP]      <= (cur_row != '0) && col_last;
            r_f2_res[RES_LEFT]    <= row_last && (cur_col != '0);
            r_f2_res[RES_SELF]    <= row_last && col_last;
            // same column written in this cycle: memory still returns old data
            r_fwd                 <= f2_adv && (r_f2_col == cur_col);
            r_fwd_prev            <= r_f2_x;
            r_fwd_prev2           <= prev_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f2_adv) begin
            r_mem_prev[r_f2_col] <= r_f2_x;
        end
        if (accept) begin
            r_rd_prev <= r_mem_prev[cur_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (f2_adv) begin
            r_mem_prev2[r_f2_col] <= prev_eff;
        end
        if (accept) begin
            r_rd_prev2 <= r_mem_prev2[cur_col];
        end
    end

endmodule

>>> hdl/bb3_job_fifo.sv
// ----------------------------------------------------------------------------
// bb3_job_fifo
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module bb3_job_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bb3_pkg::t_job   i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output bb3_pkg::t_job   o_job
);
    import bb3_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job               r_mem [DEPTH];
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

>>> hdl/bb3_back.sv
// ----------------------------------------------------------------------------
// bb3_back
// Issues job results one per cycle unless stalled: border-masked window sum,
// reciprocal multiply for the rounded mean, then the output register.
// ----------------------------------------------------------------------------
module bb3_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_job_valid,
    output logic                            o_job_ready,
    input  bb3_pkg::t_job                   i_job,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bb3_pkg::SAMPLE_W-1:0]    o_height,
    output logic [bb3_pkg::OUT_POS_W-1:0]   o_col,
    output logic [bb3_pkg::OUT_POS_W-1:0]   o_row,
    output logic                            o_last,
    output logic                            o_done
);
    import bb3_pkg::*;

    localparam int MUL_W  = 21;
    localparam int PROD_W = SUM_W + MUL_W;
    localparam int COL_W  = SAMPLE_W + 2;

    typedef enum logic [2:0] {
        DIV1 = 3'd0,
        DIV2 = 3'd1,
        DIV3 = 3'd2,
        DIV4 = 3'd3,
        DIV6 = 3'd4,
        DIV9 = 3'd5
    } t_div;

    logic [3:0]             r_issued;
    logic                   r_p1_valid;
    logic [SUM_W-1:0]       r_p1_sum;
    t_div                   r_p1_div;
    logic [OUT_POS_W-1:0]   r_p1_col;
    logic [OUT_POS_W-1:0]   r_p1_row;
    logic                   r_p1_last;
    logic                   r_p1_done;
    logic                   r_out_valid;
    logic [SAMPLE_W-1:0]    r_out_height;
    logic [OUT_POS_W-1:0]   r_out_col;
    logic [OUT_POS_W-1:0]   r_out_row;
    logic                   r_out_last;
    logic                   r_out_done;

    logic [3:0]             rem;
    t_res_kind              kind;
    logic                   last;
    logic                   issue;
    logic                   p1_ready;
    logic                   out_free;
    logic [2:0]             cm;
    logic [2:0]             rm;
    logic [COL_W-1:0]       col_sum [3];
    logic [SUM_W-1:0]       total;
    logic [1:0]             ncol;
    logic [1:0]             nrow;
    t_div                   div;
    logic [2:0]             bias;
    logic [PROD_W-1:0]      mconst;
    logic [PROD_W-1:0]      prod;
    logic [SAMPLE_W-1:0]    mean;

    assign out_free    = !r_out_valid || i_ready;
    assign p1_ready    = !r_p1_valid || out_free;
    assign issue       = i_job_valid && p1_ready;
    assign o_job_ready = issue && last;

    // next result of the head job, in fixed order
    always_comb begin
        rem = i_job.res & ~r_issued;
        if (rem[RES_UL]) begin
            kind = RES_UL;
            last = (rem[3:1] == '0);
        end else if (rem[RES_UP]) begin
            kind = RES_UP;
            last = (rem[3:2] == '0);
        end else if (rem[RES_LEFT]) begin
            kind = RES_LEFT;
            last = !rem[RES_SELF];
        end else begin
            kind = RES_SELF;
            last = 1'b1;
        end
    end

    // in-grid part of the window around the chosen pixel
    always_comb begin
        cm[0] = 1'b1;
        cm[1] = i_job.c_ge1;
        cm[2] = i_job.c_ge2 && ((kind == RES_UL) || (kind == RES_LEFT));
        rm[2] = 1'b1;
        rm[1] = i_job.r_ge1;
        rm[0] = i_job.r_ge2 && ((kind == RES_UL) || (kind == RES_UP));
        for (int j = 0; j < 3; j++) begin
            col_sum[j] = (rm[0] ? COL_W'(i_job.win[3*j])     : '0)
                       + (rm[1] ? COL_W'(i_job.win[3*j + 1]) : '0)
                       + (rm[2] ? COL_W'(i_job.win[3*j + 2]) : '0);
        end
        total = (cm[0] ? SUM_W'(col_sum[0]) : '0)
              + (cm[1] ? SUM_W'(col_sum[1]) : '0)
              + (cm[2] ? SUM_W'(col_sum[2]) : '0);
        ncol = 2'd1 + {1'b0, cm[1]} + {1'b0, cm[2]};
        nrow = 2'd1 + {1'b0, rm[1]} + {1'b0, rm[0]};
        case ({ncol, nrow})
            4'b0101: begin div = DIV1; bias = 3'd0; end
            4'b0110,
            4'b1001: begin div = DIV2; bias = 3'd1; end
            4'b0111,
            4'b1101: begin div = DIV3; bias = 3'd1; end
            4'b1010: begin div = DIV4; bias = 3'd2; end
            4'b1011,
            4'b1110: begin div = DIV6; bias = 3'd3; end
            4'b1111: begin div = DIV9; bias = 3'd4; end
            default: begin div = DIV1; bias = 3'd0; end
        endcase
    end

    // quotient by reciprocal, exact for sums below 2^20
    always_comb begin
        case (r_p1_div)
            DIV3:    mconst = PROD_W'(699051);
            DIV6:    mconst = PROD_W'(1398102);
            DIV9:    mconst = PROD_W'(1864136);
            default: mconst = PROD_W'(1);
        endcase
        prod = PROD_W'(r_p1_sum) * mconst;
        case (r_p1_div)
            DIV1:    mean = prod[15:0];
            DIV2:    mean = prod[16:1];
            DIV4:    mean = prod[17:2];
            DIV3:    mean = prod[36:21];
            DIV6:    mean = prod[38:23];
            DIV9:    mean = prod[39:24];
            default: mean = prod[15:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issued    <= '0;
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_issued <= last ? '0 : (r_issued | (4'b0001 << kind));
            end
            if (p1_ready) begin
                r_p1_valid <= issue;
            end
            if (out_free) begin
                r_out_valid <= r_p1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue && p1_ready) begin
            r_p1_sum  <= total + SUM_W'(bias);
            r_p1_div  <= div;
            r_p1_col  <= ((kind == RES_UL) || (kind == RES_LEFT)) ?
                         i_job.col - OUT_POS_W'(1) : i_job.col;
            r_p1_row  <= ((kind == RES_UL) || (kind == RES_UP)) ?
                         i_job.row - OUT_POS_W'(1) : i_job.row;
            r_p1_last <= last;
            r_p1_done <= (kind == RES_SELF);
        end
        if (r_p1_valid && out_free) begin
            r_out_height <= mean;
            r_out_col    <= r_p1_col;
            r_out_row    <= r_p1_row;
            r_out_last   <= r_p1_last;
            r_out_done   <= r_p1_done;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_height = r_out_height;
    assign o_col    = r_out_col;
    assign o_row    = r_out_row;
    assign o_last   = r_out_last;
    assign o_done   = r_out_done;

endmodule

>>> hdl/box_blur_3x3_border_aware_top.sv
// path: front stage register, job queue, back sum register, then the output register
// throughput: one sample per cycle into the front unless stalled; the back issues one result
// per cycle unless its output stalls; samples releasing several results can stall the input
// reset: synchronous, active low; clears position, window columns, queue and pipeline
// valids, grid side back to 257; line buffers are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// box_blur_3x3_border_aware_top
// Streaming 3x3 mean filter over a square grid, divisor follows the in-grid
// neighbourhood at edges and corners.
// ----------------------------------------------------------------------------
module box_blur_3x3_border_aware_top #(
    parameter int MAX_SIDE    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bb3_pkg::SIDE_W-1:0]      i_cfg_data,     // grid_side
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bb3_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // height_in
    input  logic [0:0]                      s_axis_tuser,   // frame_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bb3_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // height_out, out_column, out_row
    output logic                            m_axis_tlast,   // run_last
    output logic [0:0]                      m_axis_tuser    // frame_done
);
    import bb3_pkg::*;

    localparam int JOB_DEPTH = 4;

    t_job                   front_job;
    logic                   front_job_valid;
    logic                   front_job_ready;
    t_job                   back_job;
    logic                   back_job_valid;
    logic                   back_job_ready;
    logic [SAMPLE_W-1:0]    out_height;
    logic [OUT_POS_W-1:0]   out_col;
    logic [OUT_POS_W-1:0]   out_row;
    logic                   out_done;

    assign o_cfg_ready = 1'b1;

    bb3_front #(
        .MAX_SIDE    (MAX_SIDE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_height      (s_axis_tdata[SAMPLE_W-1:0]),
        .i_frame_start (s_axis_tuser[0]),
        .o_job_valid   (front_job_valid),
        .i_job_ready   (front_job_ready),
        .o_job         (front_job)
    );

    bb3_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_job_valid),
        .o_ready (front_job_ready),
        .i_job   (front_job),
        .o_valid (back_job_valid),
        .i_ready (back_job_ready),
        .o_job   (back_job)
    );

    bb3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (back_job_valid),
        .o_job_ready (back_job_ready),
        .i_job       (back_job),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_height    (out_height),
        .o_col       (out_col),
        .o_row       (out_row),
        .o_last      (m_axis_tlast),
        .o_done      (out_done)
    );

    assign m_axis_tdata = {4'b0000, out_row, out_col, out_height};
    assign m_axis_tuser = out_done;

endmodule

>>> hdl/bb3_checker.sv
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks on the result stream of the box blur.
// ----------------------------------------------------------------------------
module bb3_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [bb3_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            m_axis_tlast,
    input  logic [0:0]                      m_axis_tuser
);
    import bb3_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_drop_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(m_axis_tvalid) && $past(i_rst_n) |-> $past(m_axis_tready))
        else $error("result withdrawn without transfer");

    // the frame ends on the bottom-right pixel, which closes its run
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("frame end not last of its run");

    // square grid: bottom-right pixel has equal row and column
    a_done_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[25:16] == m_axis_tdata[35:26])
        else $error("frame end not on the diagonal corner");

endmodule

bind box_blur_3x3_border_aware_top bb3_checker u_bb3_checker (.*);

>>> verif/tb_box_blur_3x3_border_aware_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_border_aware_top
// Self-checking bench for the border-aware 3x3 box blur. Frames are streamed
// through the slave side and every result on the master side is compared,
// field by field, against a behavioral predictor of the filter. Covers the
// side register at reset, tiny and out-of-range sides, full-scale samples,
// shrinking the side mid-frame, the widest side, and random frames with
// stray frame starts, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_border_aware_top;
    import bb3_pkg::*;

    localparam int LINE_DEPTH   = 1024;
    localparam int PASS_IDLE    = 8;    // cycles after the last result before a side write
    localparam int RANDOM_ITEMS = 60;   // samples sent by the random frame test

    typedef struct packed {
        logic [SAMPLE_W-1:0]  height;
        logic [OUT_POS_W-1:0] col;
        logic [OUT_POS_W-1:0] row;
        logic                 last;
        logic                 done;
    } t_blur_res;

    typedef enum int {
        FILL_RANDOM,
        FILL_MAX,
        FILL_ZERO
    } t_fill;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [SIDE_W-1:0]      i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;
    logic [0:0]             m_axis_tuser;

    // predictor state
    logic [SIDE_W-1:0]      side_reg = SIDE_RESET;
    t_sample                line_prev  [LINE_DEPTH];
    t_sample                line_prev2 [LINE_DEPTH];
    bit                     line_prev_ok  [LINE_DEPTH];
    bit                     line_prev2_ok [LINE_DEPTH];
    t_sample                left_cols [6];
    int                     col_pos = 0;
    int                     row_pos = 0;

    t_blur_res              blur_expected [$];
    int                     mismatches = 0;
    bit                     steady = 1'b0;

    box_blur_3x3_border_aware_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int k = 0; k < LINE_DEPTH; k++) begin
            line_prev[k] = '0;
            line_prev2[k] = '0;
            line_prev_ok[k] = 1'b0;
            line_prev2_ok[k] = 1'b0;
        end
        for (int k = 0; k < 6; k++) begin
            left_cols[k] = '0;
        end
    end

    function automatic int eff_side();
        int s;
        s = int'(side_reg);
        if (s < 1) s = 1;
        if (s > LINE_DEPTH) s = LINE_DEPTH;
        return s;
    endfunction

    // position the next sample lands on
    function automatic void peek_spot(input logic fs, output int r, output int c);
        int s;
        s = eff_side();
        r = row_pos;
        c = col_pos;
        if (fs) begin
            r = 0;
            c = 0;
        end
        if (c >= s) begin
            c = 0;
            r = r + 1;
        end
        if (r >= s) r = 0;
    endfunction

    // cells index 3*j+i: column c-j, row r-2+i
    function automatic t_blur_res neighbourhood_mean(input logic [8:0][SAMPLE_W-1:0] cells,
                                                     input int r, input int c,
                                                     input int pr, input int pc,
                                                     input logic done);
        t_blur_res res;
        int unsigned sum;
        int unsigned cnt;
        int h;
        int g;
        sum = 0;
        cnt = 0;
        for (int j = 0; j < 3; j++) begin
            h = c - j;
            if (h >= 0 && h - pc <= 1 && pc - h <= 1) begin
                for (int i = 0; i < 3; i++) begin
                    g = r - 2 + i;
                    if (g >= 0 && g - pr <= 1 && pr - g <= 1) begin
                        sum += cells[3*j+i];
                        cnt++;
                    end
                end
            end
        end
        res.height = (cnt == 0) ? '0 : SAMPLE_W'((sum + cnt / 2) / cnt);
        res.col = OUT_POS_W'(pc);
        res.row = OUT_POS_W'(pr);
        res.last = 1'b0;
        res.done = done;
        return res;
    endfunction

    task automatic predict_sample(input t_sample x, input logic fs);
        int s;
        int r;
        int c;
        int n;
        logic [8:0][SAMPLE_W-1:0] cells;
        t_blur_res made [4];
        s = eff_side();
        peek_spot(fs, r, c);
        cells[0] = line_prev2[c];
        cells[1] = line_prev[c];
        cells[2] = x;
        for (int k = 0; k < 6; k++) begin
            cells[3+k] = left_cols[k];
        end
        n = 0;
        if (r >= 1 && c >= 1) begin
            made[n] = neighbourhood_mean(cells, r, c, r - 1, c - 1, 1'b0);
            n++;
        end
        if (r >= 1 && c == s - 1) begin
            made[n] = neighbourhood_mean(cells, r, c, r - 1, c, 1'b0);
            n++;
        end
        if (r == s - 1 && c >= 1) begin
            made[n] = neighbourhood_mean(cells, r, c, r, c - 1, 1'b0);
            n++;
        end
        if (r == s - 1 && c == s - 1) begin
            made[n] = neighbourhood_mean(cells, r, c, r, c, 1'b1);
            n++;
        end
        if (n > 0) made[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) begin
            blur_expected.push_back(made[k]);
        end
        line_prev2[c] = line_prev[c];
        line_prev[c] = x;
        line_prev2_ok[c] = line_prev_ok[c];
        line_prev_ok[c] = 1'b1;
        for (int k = 0; k < 3; k++) begin
            left_cols[3+k] = left_cols[k];
            left_cols[k] = cells[k];
        end
        col_pos = c + 1;
        row_pos = r;
        if (col_pos >= s) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= s) row_pos = 0;
        end
    endtask

    function automatic t_sample pick_height(input t_fill mode);
        int roll;
        if (mode == FILL_MAX) return '1;
        if (mode == FILL_ZERO) return '0;
        roll = $urandom_range(0, 11);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return SAMPLE_W'($urandom_range(0, 65535));
    endfunction

    // one sample transfer; valid is left high so back-to-back items stay high
    task automatic push_sample(input t_sample h, input logic fs_in);
        logic fs;
        int r;
        int c;
        fs = fs_in;
        // never let a row above be fetched from a line entry that was never written
        if (!fs) begin
            peek_spot(1'b0, r, c);
            if ((r >= 1 && !line_prev_ok[c]) || (r >= 2 && !line_prev2_ok[c])) fs = 1'b1;
        end
        if (!steady && $urandom_range(0, 99) < 9) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= h;
        s_axis_tuser <= fs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_sample(h, fs);
    endtask

    task automatic stream_run(input int n, input t_fill mode, input logic lead_fs,
                              input int noise_pct);
        logic fs;
        for (int k = 0; k < n; k++) begin
            fs = (k == 0) ? lead_fs : ($urandom_range(0, 99) < noise_pct);
            push_sample(pick_height(mode), fs);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (blur_expected.size() != 0) @(posedge i_clk);
        repeat (PASS_IDLE) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [SIDE_W-1:0] v);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        side_reg = v;
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    // side 257 from reset, position starts at the origin without a frame start
    task automatic test_default_side();
        stream_run(5, FILL_RANDOM, 1'b0, 0);
    endtask

    // sides of one and two, and zero acting as one
    task automatic test_tiny_sides();
        write_side(SIDE_W'(1));
        stream_run(3, FILL_RANDOM, 1'b0, 0);
        write_side(SIDE_W'(0));
        stream_run(3, FILL_RANDOM, 1'b1, 0);
        write_side(SIDE_W'(2));
        stream_run(4, FILL_MAX, 1'b1, 0);
        stream_run(4, FILL_ZERO, 1'b0, 0);
    endtask

    // full-scale sums at divisors four, six and nine
    task automatic test_full_scale();
        write_side(SIDE_W'(3));
        stream_run(9, FILL_MAX, 1'b1, 0);
        stream_run(9, FILL_RANDOM, 1'b0, 0);
    endtask

    // side written smaller while a frame is partly streamed
    task automatic test_side_shrink();
        write_side(SIDE_W'(4));
        stream_run(2 * 4 + 3, FILL_RANDOM, 1'b1, 0);
        // column past the new side moves down, row past it wraps to the top
        write_side(SIDE_W'(3));
        stream_run(9, FILL_RANDOM, 1'b0, 0);
    endtask

    // an oversized side acting as the widest, then the widest itself
    task automatic test_wide_side();
        write_side(SIDE_W'(2047));
        stream_run(4, FILL_RANDOM, 1'b1, 0);
        write_side(SIDE_W'(LINE_DEPTH));
        stream_run(3, FILL_RANDOM, 1'b1, 0);
    endtask

    // small random frames, repeated passes, stray frame starts, cut-off frames
    task automatic test_random_frames();
        int sent;
        int s;
        int passes;
        int n;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            s = $urandom_range(1, 5);
            write_side(SIDE_W'(s));
            passes = $urandom_range(1, 2);
            for (int p = 0; p < passes; p++) begin
                n = s * s;
                if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
                if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
                steady = (sent >= 10 && sent < 45);
                stream_run(n, FILL_RANDOM, 1'($urandom_range(0, 1)), 4);
                sent += n;
            end
        end
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------- result side

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge i_clk) begin : check_out
        t_blur_res got;
        t_blur_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.height = m_axis_tdata[SAMPLE_W-1:0];
            got.col = m_axis_tdata[SAMPLE_W+OUT_POS_W-1:SAMPLE_W];
            got.row = m_axis_tdata[SAMPLE_W+2*OUT_POS_W-1:SAMPLE_W+OUT_POS_W];
            got.last = m_axis_tlast;
            got.done = m_axis_tuser[0];
            if (blur_expected.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: height %0d col %0d row %0d last %b done %b",
                             got.height, got.col, got.row, got.last, got.done);
                mismatches++;
            end else begin
                want = blur_expected.pop_front();
                if (got !== want) begin
                    if (mismatches < 10) begin
                        $display("mismatch: exp height %0d col %0d row %0d last %b done %b",
                                 want.height, want.col, want.row, want.last, want.done);
                        $display("          got height %0d col %0d row %0d last %b done %b",
                                 got.height, got.col, got.row, got.last, got.done);
                    end
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_side();
        test_tiny_sides();
        test_full_scale();
        test_side_shrink();
        test_wide_side();
        test_random_frames();
        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS box_blur_3x3_border_aware_top");
        end else begin
            $display("FAIL box_blur_3x3_border_aware_top");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("FAIL box_blur_3x3_border_aware_top");
        $finish;
    end

endmodule

>>> box_blur_3x3_border_aware_top.f
hdl/bb3_pkg.sv
hdl/bb3_front.sv
hdl/bb3_job_fifo.sv
hdl/bb3_back.sv
hdl/box_blur_3x3_border_aware_top.sv
hdl/bb3_checker.sv
verif/tb_box_blur_3x3_border_aware_top.sv
